[rtl/cau_pkg.sv]
// ---------------------------------------------------------------------------
// cau_pkg: shared definitions for the complex arithmetic unit
// Opcode encoding and the control bundle that travels down the pipeline.
// ---------------------------------------------------------------------------
package cau_pkg;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} opcode_t;

	// Per-item control that rides along with the datapath.
	typedef struct packed {
		opcode_t op;
		logic    dbz;
	} ctl_t;

endpackage

[rtl/cau_divider.sv]
// ---------------------------------------------------------------------------
// cau_divider: pipelined signed restoring divider
// One quotient bit per stage, truncating toward zero. Each stage holds
// its own partial remainder, so a new division may enter every cycle in which advance is high.
// ---------------------------------------------------------------------------
module cau_divider
	import cau_pkg::*;
#(
	parameter int NW = 100,
	parameter int DW = 66,
	parameter int TW = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic                   in_valid,
	input  logic signed [NW-1:0]   num,
	input  logic        [DW-1:0]   den,
	input  logic        [TW-1:0]   tag,
	output logic                   out_valid,
	output logic signed [NW:0]     quo,
	output logic        [TW-1:0]   out_tag
);

	localparam int RW = DW + 1;

	logic [NW-1:0] q_s   [0:NW];
	logic [RW-1:0] rem_s [0:NW];
	logic [DW-1:0] den_s [0:NW];
	logic          neg_s [0:NW];
	logic [TW-1:0] tag_s [0:NW];
	logic          vld_s [0:NW];

	// Stage 0 takes the magnitude of the numerator.
	always_ff @(posedge clk) begin
		if (advance) begin
			q_s[0]   <= num[NW-1] ? NW'(-num) : NW'(num);
			rem_s[0] <= '0;
			den_s[0] <= den;
			neg_s[0] <= num[NW-1];
			tag_s[0] <= tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (advance) begin
			vld_s[0] <= in_valid;
		end
	end

	for (genvar i = 0; i < NW; i++) begin : g_step
		logic [RW:0]   trial;
		logic [RW-1:0] shifted;
		always_comb begin
			shifted = {rem_s[i][RW-2:0], q_s[i][NW-1]};
			trial   = {1'b0, shifted} - {2'b00, den_s[i]};
		end
		always_ff @(posedge clk) begin
			if (advance) begin
				if (!trial[RW]) begin
					rem_s[i+1] <= trial[RW-1:0];
				end else begin
					rem_s[i+1] <= shifted;
				end
				q_s[i+1]   <= {q_s[i][NW-2:0], ~trial[RW]};
				den_s[i+1] <= den_s[i];
				neg_s[i+1] <= neg_s[i];
				tag_s[i+1] <= tag_s[i];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (advance) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
	end

	assign out_valid = vld_s[NW];
	assign out_tag   = tag_s[NW];
	assign quo = neg_s[NW] ? -$signed({1'b0, q_s[NW]}) : $signed({1'b0, q_s[NW]});

endmodule

[rtl/complex_arithmetic_unit.sv]
// ---------------------------------------------------------------------------
// complex_arithmetic_unit: complex ALU on signed fixed-point operands
// Add, subtract, multiply and divide of two complex numbers with
// saturation and a divide-by-zero flag.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries opcode and the operands
//   a and b. The output channel (out_valid/out_ready) carries the result
//   parts and the two flags. Each transaction in gives exactly one out.
//   Every operation travels the same pipeline, so results leave in order.
//   The divider, one quotient bit per stage, makes up most of the pipeline.
//   Throughput is one transaction per cycle while the receiver keeps up.
//   The whole pipeline moves only when the output register is empty or is
//   being read. When the receiver stalls, every stage holds and in_ready
//   falls; nothing is lost or repeated.
//   Reset clears all valid bits; the pipeline starts empty.
// ---------------------------------------------------------------------------
module complex_arithmetic_unit
	import cau_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   opcode,
	input  logic signed [DATA_WIDTH-1:0] a_real,
	input  logic signed [DATA_WIDTH-1:0] a_imag,
	input  logic signed [DATA_WIDTH-1:0] b_real,
	input  logic signed [DATA_WIDTH-1:0] b_imag,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] result_real,
	output logic signed [DATA_WIDTH-1:0] result_imag,
	output logic                         divide_by_zero,
	output logic                         saturated
);

	localparam int PW = 2 * DATA_WIDTH;      // one product
	localparam int SW = PW + 1;              // sum of two products
	localparam int NW = SW + FRAC_BITS;      // scaled numerator
	localparam int DW = PW + 1;              // divisor magnitude
	localparam int TW = $bits(ctl_t);
	localparam int WW = NW + 1;              // common result width

	logic advance;
	assign advance  = !out_valid || out_ready;
	assign in_ready = advance;

	// Stage 1: register operands.
	logic                         v_s1;
	ctl_t                         ctl_s1;
	logic signed [DATA_WIDTH-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s1 <= '{op: opcode_t'(opcode), dbz: 1'b0};
			ar_s1 <= a_real;
			ai_s1 <= a_imag;
			br_s1 <= b_real;
			bi_s1 <= b_imag;
		end
	end

	// Stage 2: the six products, each in its own multiplier, and the sum or difference.
	logic                 v_s2;
	ctl_t                 ctl_s2;
	logic signed [PW-1:0] rr_s2, ii_s2, ri_s2, ir_s2, brr_s2, bii_s2;
	logic signed [DATA_WIDTH:0] sr_s2, si_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s2 <= ctl_s1;
			rr_s2  <= ar_s1 * br_s1;
			ii_s2  <= ai_s1 * bi_s1;
			ri_s2  <= ar_s1 * bi_s1;
			ir_s2  <= ai_s1 * br_s1;
			brr_s2 <= br_s1 * br_s1;
			bii_s2 <= bi_s1 * bi_s1;
			if (ctl_s1.op == OP_SUB) begin
				sr_s2 <= (DATA_WIDTH+1)'(ar_s1) - (DATA_WIDTH+1)'(br_s1);
				si_s2 <= (DATA_WIDTH+1)'(ai_s1) - (DATA_WIDTH+1)'(bi_s1);
			end else begin
				sr_s2 <= (DATA_WIDTH+1)'(ar_s1) + (DATA_WIDTH+1)'(br_s1);
				si_s2 <= (DATA_WIDTH+1)'(ai_s1) + (DATA_WIDTH+1)'(bi_s1);
			end
		end
	end

	// Stage 3: sums of products and the divisor.
	logic                 v_s3;
	ctl_t                 ctl_s3;
	logic signed [SW-1:0] mre_s3, mim_s3, dre_s3, dim_s3;
	logic        [DW-1:0] den_s3;
	logic signed [DATA_WIDTH:0] sr_s3, si_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s3 <= ctl_s2;
			mre_s3 <= SW'(rr_s2) - SW'(ii_s2);
			mim_s3 <= SW'(ri_s2) + SW'(ir_s2);
			dre_s3 <= SW'(rr_s2) + SW'(ii_s2);
			dim_s3 <= SW'(ir_s2) - SW'(ri_s2);
			den_s3 <= DW'($unsigned(brr_s2)) + DW'($unsigned(bii_s2));
			sr_s3  <= sr_s2;
			si_s3  <= si_s2;
		end
	end

	// Stage 4: pick the value headed for each divider lane. Add and
	// subtract divide by one with no scale; multiply divides by 2^FRAC.
	logic                 v_s4;
	ctl_t                 ctl_s4;
	logic signed [NW-1:0] nre_s4, nim_s4;
	logic        [DW-1:0] den_s4;
	logic signed [NW-1:0] nre_d, nim_d;
	logic        [DW-1:0] den_d;
	logic                 dbz_d;

	always_comb begin
		dbz_d = 1'b0;
		case (ctl_s3.op)
			OP_MUL: begin
				nre_d = NW'(mre_s3);
				nim_d = NW'(mim_s3);
				den_d = DW'(1) << FRAC_BITS;
			end
			OP_DIV: begin
				if (den_s3 == '0) begin
					nre_d = '0;
					nim_d = '0;
					den_d = DW'(1);
					dbz_d = 1'b1;
				end else begin
					nre_d = NW'(dre_s3) <<< FRAC_BITS;
					nim_d = NW'(dim_s3) <<< FRAC_BITS;
					den_d = den_s3;
				end
			end
			default: begin
				nre_d = NW'(sr_s3);
				nim_d = NW'(si_s3);
				den_d = DW'(1);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s4 <= '{op: ctl_s3.op, dbz: dbz_d};
			nre_s4 <= nre_d;
			nim_s4 <= nim_d;
			den_s4 <= den_d;
		end
	end

	// Divider lanes.
	logic                 dv_re, dv_im;
	logic signed [NW:0]   q_re, q_im;
	logic        [TW-1:0] tag_re, tag_im;

	cau_divider #(.NW(NW), .DW(DW), .TW(TW)) u_div_re (
		.clk, .arst_n, .advance,
		.in_valid (v_s4), .num (nre_s4), .den (den_s4), .tag (ctl_s4),
		.out_valid(dv_re), .quo (q_re), .out_tag (tag_re)
	);
	cau_divider #(.NW(NW), .DW(DW), .TW(TW)) u_div_im (
		.clk, .arst_n, .advance,
		.in_valid (v_s4), .num (nim_s4), .den (den_s4), .tag (ctl_s4),
		.out_valid(dv_im), .quo (q_im), .out_tag (tag_im)
	);

	// Saturation stage feeding the output register.
	localparam logic signed [WW-1:0] MAXV = WW'((64'sd1 <<< (DATA_WIDTH-1)) - 1);
	localparam logic signed [WW-1:0] MINV = -WW'(64'sd1 <<< (DATA_WIDTH-1));

	logic hi_re, lo_re, hi_im, lo_im;
	logic signed [DATA_WIDTH-1:0] sat_re, sat_im;
	ctl_t ctl_out;

	always_comb begin
		ctl_out = ctl_t'(tag_re);
		hi_re = q_re > MAXV;
		lo_re = q_re < MINV;
		hi_im = q_im > MAXV;
		lo_im = q_im < MINV;
		sat_re = hi_re ? MAXV[DATA_WIDTH-1:0] : lo_re ? MINV[DATA_WIDTH-1:0]
		                                             : q_re[DATA_WIDTH-1:0];
		sat_im = hi_im ? MAXV[DATA_WIDTH-1:0] : lo_im ? MINV[DATA_WIDTH-1:0]
		                                             : q_im[DATA_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= dv_re;
		end
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			result_real    <= sat_re;
			result_imag    <= sat_im;
			divide_by_zero <= ctl_out.dbz;
			saturated      <= hi_re | lo_re | hi_im | lo_im;
		end
	end

	// Checks on the pipeline.
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		dv_re == dv_im && (!dv_re || tag_re == tag_im))
		else $error("divider lanes out of step");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_real)
		&& $stable(result_imag))
		else $error("result changed while stalled");

	a_dbz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> result_real == '0 && result_imag == '0
		&& !saturated)
		else $error("divide by zero result not cleared");

endmodule

[tb/testbench.sv]
// ---------------------------------------------------------------------------
// testbench: self-checking bench for complex_arithmetic_unit
// Drives opcodes and operands through the input handshake with random gaps,
// predicts each result with wide exact arithmetic, and compares every
// output transaction field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module testbench;
	import cau_pkg::*;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int LATENCY    = 2 * DATA_WIDTH + FRAC_BITS + 8;

	typedef logic signed [DATA_WIDTH-1:0] word_t;
	typedef logic signed [127:0] wide_t;
	typedef struct {
		word_t re;
		word_t im;
		logic  dbz;
		logic  sat;
	} cplx_result_t;

	localparam word_t MAX_W = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam word_t MIN_W = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [1:0] opcode;
	word_t a_real, a_imag, b_real, b_imag;
	word_t result_real, result_imag;
	logic divide_by_zero, saturated;

	cplx_result_t expected_results[$];
	int errors = 0;

	complex_arithmetic_unit uut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic word_t clamp(wide_t v, inout logic sat);
		if (v > wide_t'(MAX_W)) begin
			sat = 1;
			return MAX_W;
		end
		if (v < wide_t'(MIN_W)) begin
			sat = 1;
			return MIN_W;
		end
		return word_t'(v);
	endfunction

	function automatic cplx_result_t predict_result(opcode_t op, word_t ar, word_t ai,
			word_t br, word_t bi);
		cplx_result_t r;
		wide_t re, im, den, scale;
		scale = wide_t'(1) <<< FRAC_BITS;
		r.dbz = 0;
		r.sat = 0;
		case (op)
			OP_ADD: begin
				re = wide_t'(ar) + wide_t'(br);
				im = wide_t'(ai) + wide_t'(bi);
			end
			OP_SUB: begin
				re = wide_t'(ar) - wide_t'(br);
				im = wide_t'(ai) - wide_t'(bi);
			end
			OP_MUL: begin
				re = (wide_t'(ar) * wide_t'(br) - wide_t'(ai) * wide_t'(bi)) / scale;
				im = (wide_t'(ar) * wide_t'(bi) + wide_t'(ai) * wide_t'(br)) / scale;
			end
			default: begin
				den = wide_t'(br) * wide_t'(br) + wide_t'(bi) * wide_t'(bi);
				if (den == 0) begin
					r.dbz = 1;
					re = 0;
					im = 0;
				end else begin
					re = ((wide_t'(ar) * wide_t'(br) + wide_t'(ai) * wide_t'(bi)) * scale) / den;
					im = ((wide_t'(ai) * wide_t'(br) - wide_t'(ar) * wide_t'(bi)) * scale) / den;
				end
			end
		endcase
		r.re = clamp(re, r.sat);
		r.im = clamp(im, r.sat);
		return r;
	endfunction

	// Sends one transaction; valid stays high across back-to-back items.
	task automatic send_item(opcode_t op, word_t ar, word_t ai, word_t br, word_t bi);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		opcode <= op;
		a_real <= ar;
		a_imag <= ai;
		b_real <= br;
		b_imag <= bi;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_results.push_back(predict_result(op, ar, ai, br, bi));
	endtask

	// Output side: check each transaction, then draw a stall for the next one.
	initial begin
		int stall;
		cplx_result_t exp_r;
		stall = 0;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no transaction pending: %0d %0d", result_real, result_imag);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (result_real !== exp_r.re) begin
						$error("result_real expected %0d actual %0d", exp_r.re, result_real);
						errors++;
					end
					if (result_imag !== exp_r.im) begin
						$error("result_imag expected %0d actual %0d", exp_r.im, result_imag);
						errors++;
					end
					if (divide_by_zero !== exp_r.dbz) begin
						$error("divide_by_zero expected %0b actual %0b", exp_r.dbz, divide_by_zero);
						errors++;
					end
					if (saturated !== exp_r.sat) begin
						$error("saturated expected %0b actual %0b", exp_r.sat, saturated);
						errors++;
					end
				end
				stall = $urandom_range(0, 4);
			end
			if (stall != 0) begin
				out_ready <= 0;
				stall--;
			end else begin
				out_ready <= 1;
			end
		end
	end

	function automatic word_t rand_operand();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return MAX_W;
			2: return MIN_W;
			3: return word_t'(signed'(16'($urandom)));
			4: return word_t'(signed'(24'($urandom)));
			default: return word_t'(signed'(20'($urandom)));
		endcase
	endfunction

	task automatic test_add_sub_extremes();
		send_item(OP_ADD, 0, 0, 0, 0);
		send_item(OP_ADD, MAX_W, MIN_W, MAX_W, MIN_W);
		send_item(OP_ADD, MAX_W, MIN_W, MIN_W, MAX_W);
		send_item(OP_ADD, -1, -1, 1, 1);
		send_item(OP_SUB, MIN_W, MAX_W, MAX_W, MIN_W);
		send_item(OP_SUB, MAX_W, MIN_W, MAX_W, MIN_W);
		send_item(OP_SUB, 0, 0, MIN_W, MIN_W);
	endtask

	task automatic test_multiply();
		send_item(OP_MUL, 32'h0001_0000, 0, 32'h0002_8000, 32'hFFFF_0000);
		send_item(OP_MUL, MIN_W, MIN_W, MIN_W, MIN_W);
		send_item(OP_MUL, MAX_W, MIN_W, MAX_W, MAX_W);
		send_item(OP_MUL, -1, 1, 1, 1);
		send_item(OP_MUL, 32'h0003_0000, 32'hFFFE_0000, 32'h0000_8000, 32'h0001_0000);
	endtask

	task automatic test_divide();
		send_item(OP_DIV, 32'h0001_0000, 32'h0002_0000, 0, 0);
		send_item(OP_DIV, MAX_W, MIN_W, 0, 0);
		send_item(OP_DIV, 32'h0001_0000, 0, 32'h0003_0000, 0);
		send_item(OP_DIV, MAX_W, MAX_W, 1, 0);
		send_item(OP_DIV, MIN_W, MIN_W, 0, -1);
		send_item(OP_DIV, -7, 3, MIN_W, MAX_W);
		send_item(OP_DIV, 32'h0005_0000, -32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
	endtask

	task automatic test_random(int count);
		word_t br, bi;
		for (int i = 0; i < count; i++) begin
			br = rand_operand();
			bi = rand_operand();
			// Every opcode, divides included, gets a zero b now and then and a small real part of b often.
			if ($urandom_range(0, 9) == 0) begin
				br = 0;
				bi = 0;
			end else if ($urandom_range(0, 2) == 0) begin
				br = word_t'(signed'(8'($urandom)));
			end
			send_item(opcode_t'($urandom_range(0, 3)), rand_operand(), rand_operand(), br, bi);
		end
	endtask

	task automatic test_drain_and_resume();
		in_valid <= 0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		test_random(50);
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		opcode = '0;
		a_real = '0;
		a_imag = '0;
		b_real = '0;
		b_imag = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_add_sub_extremes();
		test_multiply();
		test_divide();
		test_random(150);
		test_drain_and_resume();
		test_random(200);
		in_valid <= 0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

[files.f]
rtl/cau_pkg.sv
rtl/cau_divider.sv
rtl/complex_arithmetic_unit.sv
tb/testbench.sv
